[sv/sha1h_pkg.sv]
// Package for the SHA-1 message hash block: types, constants, round helpers.
package sha1h_pkg;

    localparam int WORD_W = 32;
    localparam int FIFO_DEPTH = 4;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    // One accepted item, normalized by the front end.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYTES,
        ST_PAD,
        ST_COMP,
        ST_EMIT
    } back_state_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h67452301;
            3'd1: r = 32'hEFCDAB89;
            3'd2: r = 32'h98BADCFE;
            3'd3: r = 32'h10325476;
            3'd4: r = 32'hC3D2E1F0;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t rol(input word_t x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

[sv/sha1_message_hash_top.sv]
// Top level of the SHA-1 message hash block.
// Usage:
//   Input channel s_*: one item per handshake carries a big-endian word,
//   a byte count (0..4, 5..7 treated as 4) and a last flag. Only the last
//   item of a message may be short.
//   Output channel m_*: after a last item, five items carry the digest
//   words, index 0 first; m_last_word marks the fifth. m_length_overflow
//   reports a wrap of the 64-bit bit counter for that message.
//   Rate: items are handled one at a time. The back end fetches an item
//   from the queue, packs its bytes into the block and then closes the
//   item; each 64-byte block is compressed at one round per cycle.
//   After a last item the padding completes the current block, or needs
//   a second block when it does not fit; the five words then go out one
//   per accepted cycle.
//   A four-entry queue lets the sender run ahead of the back end.
//   Reset (aresetn low, synchronous) restores the initial chain value and
//   clears counts and the queue.
//   If the receiver stalls, the digest word is held and the back end waits;
//   the queue keeps taking items until it is full.
module sha1_message_hash_top
    import sha1h_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_of_message,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_length_overflow,
    output logic        m_valid,
    input  logic        m_ready
);
    item_t q_item;
    logic  q_valid, q_ready;

    sha1h_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .aclk, .aresetn, .s_data_word, .s_byte_count, .s_last_of_message,
        .s_valid, .s_ready, .q_item, .q_valid, .q_ready
    );

    sha1h_back u_back (
        .aclk, .aresetn, .q_item, .q_valid, .q_ready,
        .m_digest_word, .m_word_index, .m_last_word, .m_length_overflow,
        .m_valid, .m_ready
    );
endmodule

[sv/sha1h_front.sv]
// Front end: accepts items, clamps byte counts, and queues them.
module sha1h_front
    import sha1h_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_of_message,
    input  logic        s_valid,
    output logic        s_ready,
    output sha1h_pkg::item_t q_item,
    output logic        q_valid,
    input  logic        q_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t mem [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0] cnt_reg, cnt_next;
    item_t in_item;
    logic push, pop;

    always_comb begin
        in_item.data = s_data_word;
        in_item.cnt  = (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;
        in_item.last = s_last_of_message;
    end

    assign s_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rp_reg];
    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wp_next = push ? ((wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next = pop ? ((rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= in_item;
    end
endmodule

[sv/sha1h_back.sv]
// Back end: byte packing, padding, 80-round compression and digest output.
module sha1h_back
    import sha1h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha1h_pkg::item_t q_item,
    input  logic        q_valid,
    output logic        q_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_length_overflow,
    output logic        m_valid,
    input  logic        m_ready
);
    back_state_t st_reg, st_next;
    word_t h_reg [5];
    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic        ovf_reg;
    item_t       cur_reg;
    logic [2:0]  bi_reg;
    logic [6:0]  rnd_reg;
    logic        pad_mode_reg;
    logic [3:0]  pad_step_reg;
    logic [63:0] plen_reg;
    logic [2:0]  oi_reg;

    logic [7:0]  nb;
    logic [3:0]  widx;
    logic [1:0]  wpos;
    word_t       f, k, t, wnew, wcur;
    logic [63:0] len_sum;

    assign widx = fill_reg[5:2];
    assign wpos = fill_reg[1:0];
    assign q_ready = (st_reg == ST_IDLE);
    assign len_sum = len_reg + {58'd0, cur_reg.cnt, 3'd0};

    // Next byte: message byte, pad byte, zero fill or length byte.
    always_comb begin
        nb = 8'h00;
        if (st_reg == ST_BYTES) begin
            case (bi_reg[1:0])
                2'd0: nb = cur_reg.data[31:24];
                2'd1: nb = cur_reg.data[23:16];
                2'd2: nb = cur_reg.data[15:8];
                2'd3: nb = cur_reg.data[7:0];
                default: nb = 8'h00;
            endcase
        end else if (pad_step_reg == 4'd0) begin
            nb = PAD_BYTE;
        end else if (pad_step_reg >= 4'd2) begin
            nb = plen_reg[63:56];
        end
    end

    always_comb begin
        wcur = (rnd_reg < 7'd16) ? w_reg[rnd_reg[3:0]] :
               rol(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        wnew = wcur;
        if (rnd_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = K0;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg; k = K1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg; k = K3;
        end
        t = rol(a_reg, 5) + f + e_reg + wcur + k;
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (q_valid) st_next = ST_BYTES;
            ST_BYTES: begin
                if (bi_reg >= cur_reg.cnt) st_next = cur_reg.last ? ST_PAD : ST_IDLE;
                else if (fill_reg == 6'd63) st_next = ST_COMP;
            end
            ST_PAD: if (fill_reg == 6'd63) st_next = ST_COMP;
            ST_COMP: begin
                if (rnd_reg == 7'd80) begin
                    if (!pad_mode_reg) st_next = ST_BYTES;
                    else if (pad_step_reg == 4'd10) st_next = ST_EMIT;
                    else st_next = ST_PAD;
                end
            end
            ST_EMIT: if (m_ready && oi_reg == 3'd4) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= ST_IDLE;
        else st_reg <= st_next;
    end

    assign m_valid = (st_reg == ST_EMIT);
    assign m_digest_word = h_reg[oi_reg];
    assign m_word_index = oi_reg;
    assign m_last_word = (oi_reg == 3'd4);
    assign m_length_overflow = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) h_reg[i] <= iv_word(3'(i));
            fill_reg <= '0; len_reg <= '0; ovf_reg <= 1'b0;
            pad_mode_reg <= 1'b0; oi_reg <= '0; rnd_reg <= '0;
            bi_reg <= '0; pad_step_reg <= '0;
        end else begin
            case (st_reg)
                ST_IDLE: if (q_valid) begin
                    cur_reg <= q_item;
                    bi_reg <= '0;
                end
                ST_BYTES: begin
                    if (bi_reg < cur_reg.cnt) begin
                        if (wpos == 2'd0) w_reg[widx] <= {nb, 24'd0};
                        else w_reg[widx] <= w_reg[widx] | ({24'd0, nb} << (24 - 8 * wpos));
                        fill_reg <= fill_reg + 1'b1;
                        bi_reg <= bi_reg + 1'b1;
                    end else begin
                        len_reg <= len_sum;
                        if (len_sum < len_reg) ovf_reg <= 1'b1;
                        pad_mode_reg <= cur_reg.last;
                        pad_step_reg <= '0;
                        plen_reg <= len_sum;
                    end
                    rnd_reg <= '0;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                ST_PAD: begin
                    if (wpos == 2'd0) w_reg[widx] <= {nb, 24'd0};
                    else w_reg[widx] <= w_reg[widx] | ({24'd0, nb} << (24 - 8 * wpos));
                    fill_reg <= fill_reg + 1'b1;
                    // Step 0 pad byte, 1 zero fill until byte 56, 2..9 length bytes.
                    if (pad_step_reg == 4'd0) begin
                        pad_step_reg <= (fill_reg == 6'd55) ? 4'd2 : 4'd1;
                    end else if (pad_step_reg == 4'd1) begin
                        if (fill_reg == 6'd55) pad_step_reg <= 4'd2;
                    end else begin
                        plen_reg <= {plen_reg[55:0], 8'd0};
                        pad_step_reg <= pad_step_reg + 1'b1;
                    end
                    rnd_reg <= '0;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                ST_COMP: begin
                    if (rnd_reg == 7'd80) begin
                        h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                        h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                        h_reg[4] <= h_reg[4] + e_reg;
                        oi_reg <= '0;
                        // Step 10 here means length done; the pad byte fell in
                        // the prior block when step is still 1.
                        if (pad_mode_reg && pad_step_reg == 4'd0) pad_step_reg <= 4'd1;
                    end else begin
                        e_reg <= d_reg; d_reg <= c_reg; c_reg <= rol(b_reg, 30);
                        b_reg <= a_reg; a_reg <= t;
                        if (rnd_reg >= 7'd16) begin
                            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                            w_reg[15] <= wnew;
                        end else if (rnd_reg == 7'd15) begin
                            // keep window aligned: rounds 16+ use a sliding window
                        end
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                end
                ST_EMIT: if (m_ready) begin
                    oi_reg <= (oi_reg == 3'd4) ? 3'd0 : oi_reg + 1'b1;
                    if (oi_reg == 3'd4) begin
                        for (int i = 0; i < 5; i++) h_reg[i] <= iv_word(3'(i));
                        fill_reg <= '0; len_reg <= '0; ovf_reg <= 1'b0;
                        pad_mode_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[sv/sha1h_checker.sv]
// Port-level checker for the SHA-1 message hash block, with its bind.
module sha1h_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_word_index,
    input logic       m_last_word,
    input logic       m_length_overflow
);
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd4)))
        else $error("last_word mismatch");
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=> (m_valid &&
        m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest index skipped");
    a_ovf_same: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=>
        (m_length_overflow == $past(m_length_overflow)))
        else $error("overflow flag changed in digest");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_word_index)))
        else $error("stalled item dropped");
endmodule

bind sha1_message_hash_top sha1h_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_word_index, .m_last_word,
    .m_length_overflow
);
